>>> src/bsfn_pkg.sv
// Shared constants, command/status types and a helper function for the bitmap block.
`timescale 1ns / 1ps
`default_nettype none

package bsfn_pkg;

   localparam int WORD_COUNT = 4;
   localparam int WORD_W     = 64;
   localparam int WORD_IDX_W = 2;
   localparam int BIT_IDX_W  = 6;
   localparam int POS_W      = WORD_IDX_W + BIT_IDX_W;
   localparam int FUNC_W     = 3;
   localparam int COUNT_W    = 9;

   localparam logic [COUNT_W-1:0] BIT_COUNT_RESET = 9'd256;

   localparam logic [FUNC_W-1:0] FUNC_SET       = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_MASK      = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_INTERSECT = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_OVERLAP   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_ZERO      = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_FIND      = 3'd6;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture the accepted transfer
      logic step;     // process the currently addressed word
      logic publish;  // move the result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic finish;   // the current step completes the item
   } stat_type;

   // Index of the lowest set bit; 0 for an all-zero word.
   function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0]    iso;
      logic [BIT_IDX_W-1:0] idx;
      iso = w & (~w + WORD_W'(1));
      idx = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (iso[i]) begin
            idx = idx | BIT_IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

>>> src/bsfn_datapath.sv
// Datapath: bitmap words, operand registers, word walk, overlap accumulator, result register.
`timescale 1ns / 1ps
`default_nettype none

module bsfn_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  wire [bsfn_pkg::FUNC_W-1:0]       in_func,
   input  wire [bsfn_pkg::POS_W-1:0]        in_pos,
   input  wire [bsfn_pkg::WORD_IDX_W-1:0]   in_word_num,
   input  wire [bsfn_pkg::WORD_W-1:0]       in_operand,
   input  wire                              in_last,
   input  wire                              csr_wr_en,
   input  wire [bsfn_pkg::COUNT_W-1:0]      csr_wr_data,
   input  wire bsfn_pkg::cmd_type           cmd,
   output bsfn_pkg::stat_type               stat,
   output logic                             out_flag,
   output logic [bsfn_pkg::POS_W-1:0]       out_found
);
   import bsfn_pkg::*;

   logic [WORD_W-1:0]     words_ff [WORD_COUNT];
   logic [COUNT_W-1:0]    bit_count_ff;
   logic                  overlap_ff, overlap_in;

   logic [FUNC_W-1:0]     func_ff;
   logic [BIT_IDX_W-1:0]  bsel_ff;
   logic [WORD_W-1:0]     operand_ff;
   logic                  last_ff;
   logic                  eligible_ff;
   logic                  first_ff, first_in;
   logic [WORD_IDX_W-1:0] idx_ff, idx_in;
   logic                  flag_ff, flag_in;
   logic [POS_W-1:0]      found_ff, found_in;
   logic                  rsp_flag_ff;
   logic [POS_W-1:0]      rsp_found_ff;

   logic [WORD_W-1:0]     rd_word;
   logic [WORD_W-1:0]     wr_word;
   logic                  wr_en;
   logic [WORD_W-1:0]     bit_mask;
   logic [WORD_W-1:0]     search_mask;
   logic [WORD_W-1:0]     hits;
   logic                  idx_last;
   logic                  finish;

   assign rd_word     = words_ff[idx_ff];
   assign bit_mask    = WORD_W'(1) << bsel_ff;
   // first word: bits strictly above the start (none at the top bit); later words: all bits
   assign search_mask = first_ff ? ((~WORD_W'(0) << bsel_ff) << 1) : ~WORD_W'(0);
   assign hits        = rd_word & search_mask;
   assign idx_last    = (idx_ff == WORD_IDX_W'(WORD_COUNT - 1));

   always_comb begin
      wr_en      = 1'b0;
      wr_word    = rd_word;
      overlap_in = overlap_ff;
      flag_in    = flag_ff;
      found_in   = found_ff;
      idx_in     = idx_ff;
      first_in   = first_ff;
      finish     = 1'b1;
      if (cmd.step) begin
         case (func_ff)
            FUNC_SET: begin
               wr_en   = 1'b1;
               wr_word = rd_word | bit_mask;
            end
            FUNC_CLEAR: begin
               wr_en   = 1'b1;
               wr_word = rd_word & ~bit_mask;
            end
            FUNC_MASK: begin
               wr_en   = 1'b1;
               wr_word = rd_word & bit_mask;
            end
            FUNC_INTERSECT: begin
               wr_en   = 1'b1;
               wr_word = rd_word & operand_ff;
            end
            FUNC_OVERLAP: begin
               flag_in    = overlap_ff | (|(rd_word & operand_ff));
               overlap_in = last_ff ? 1'b0 : flag_in;
            end
            FUNC_ZERO: begin
               if (rd_word != '0) begin
                  flag_in = 1'b0;
               end
               finish = idx_last;
               idx_in = idx_ff + 1'b1;
            end
            FUNC_FIND: begin
               if (!eligible_ff) begin
                  finish = 1'b1;
               end else if (hits != '0) begin
                  flag_in  = 1'b1;
                  found_in = {idx_ff, lowest_set(hits)};
                  finish   = 1'b1;
               end else begin
                  finish = idx_last;
               end
               idx_in   = idx_ff + 1'b1;
               first_in = 1'b0;
            end
            default: begin
               finish = 1'b1;
            end
         endcase
      end
   end

   assign stat.finish = finish;

   // persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WORD_COUNT; i++) begin
            words_ff[i] <= '0;
         end
         overlap_ff   <= 1'b0;
         bit_count_ff <= BIT_COUNT_RESET;
      end else begin
         if (wr_en) begin
            words_ff[idx_ff] <= wr_word;
         end
         overlap_ff <= overlap_in;
         if (csr_wr_en) begin
            bit_count_ff <= csr_wr_data;
         end
      end
   end

   // per-item working registers and the output register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff     <= in_func;
         bsel_ff     <= in_pos[BIT_IDX_W-1:0];
         operand_ff  <= in_operand;
         last_ff     <= in_last;
         eligible_ff <= ({1'b0, in_pos} < bit_count_ff);
         first_ff    <= 1'b1;
         flag_ff     <= (in_func == FUNC_ZERO);
         found_ff    <= '0;
         if (in_func == FUNC_INTERSECT || in_func == FUNC_OVERLAP) begin
            idx_ff <= in_word_num;
         end else if (in_func == FUNC_ZERO) begin
            idx_ff <= '0;
         end else begin
            idx_ff <= in_pos[POS_W-1:BIT_IDX_W];
         end
      end else begin
         first_ff <= first_in;
         flag_ff  <= flag_in;
         found_ff <= found_in;
         idx_ff   <= idx_in;
      end
      if (cmd.publish) begin
         rsp_flag_ff  <= flag_in;
         rsp_found_ff <= found_in;
      end
   end

   assign out_flag  = rsp_flag_ff;
   assign out_found = rsp_found_ff;

endmodule

`default_nettype wire

>>> src/bsfn_ctrl.sv
// Controller: accept, run and output-register handshake sequencing.
`timescale 1ns / 1ps
`default_nettype none

module bsfn_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   output bsfn_pkg::cmd_type        cmd,
   input  wire bsfn_pkg::stat_type  stat
);
   import bsfn_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (stat.finish) begin
               if (out_free) begin
                  cmd.publish = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.publish ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result published over an untaken result");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_RUN))
      else $error("accepted transfer did not start a run");

   a_valid_from_publish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.publish))
      else $error("result valid without a publish");

   a_step_only_running: assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.load) |-> !(cmd.step && cmd.load))
      else $error("load and step in the same cycle");

endmodule

`default_nettype wire

>>> src/bitmap_set_find_next.sv
// Top level: bitmap with bit edits, word intersect, overlap test, zero test and find-next.
//
//   channel   direction  accept               payload
//   req_*     in         tvalid && tready     tuser=func, tlast=last_word, tdata=pos/word/operand
//   rsp_*     out        tvalid && tready     tdata=answer_flag, found_position
//   csr_*     in         csr_wr_en            csr_wr_data=bit_count
//
// Flow: the idle state takes the transfer; set, clear, mask, intersect and overlap test
// then use the addressed word alone, zero test walks all four words and find-next walks
// from the start word to the first hit or the last word, one word per cycle through
// the single word read port. A new item is taken only once the last is published.
// Reset (synchronous) clears the bitmap and the overlap accumulator and sets
// bit_count to 256; no clearing pass follows.
// Stalls: a finished result waits in the output register while the next item is
// taken and worked; a finished item holds in the controller until that register frees.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_set_find_next (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [7:0] bit_position, [9:8] word_number, [73:10] operand_word, [79:74] zero
   input  wire  [79:0] req_tdata,
   // [2:0] func
   input  wire  [2:0]  req_tuser,
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [0] answer_flag, [8:1] found_position, [15:9] zero
   output logic [15:0] rsp_tdata,
   input  wire         csr_wr_en,
   input  wire  [8:0]  csr_wr_data
);
   import bsfn_pkg::*;

   cmd_type           cmd;
   stat_type          stat;
   logic              out_flag;
   logic [POS_W-1:0]  out_found;

   // sequence accept, word walk and result hand-off
   bsfn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // unpack the transfer fields straight into the datapath
   bsfn_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .in_func     (req_tuser),
      .in_pos      (req_tdata[7:0]),
      .in_word_num (req_tdata[9:8]),
      .in_operand  (req_tdata[73:10]),
      .in_last     (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .out_flag    (out_flag),
      .out_found   (out_found)
   );

   // pack the result, pad to whole bytes
   assign rsp_tdata = {7'd0, out_found, out_flag};

endmodule

`default_nettype wire

>>> verif/bitmap_result_checker.sv
// Checker for bitmap_set_find_next: tracks the bitmap, predicts each result and compares.
`timescale 1ns / 1ps

module bitmap_result_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [79:0] req_tdata,
   input  wire  [2:0]  req_tuser,
   input  wire         req_tlast,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [15:0] rsp_tdata,
   input  wire         csr_wr_en,
   input  wire  [8:0]  csr_wr_data,
   output int          mismatch_count,
   output int          pending_count
);
   import bsfn_pkg::*;

   typedef struct packed {
      logic             flag;
      logic [POS_W-1:0] position;
   } answer_type;

   logic [WORD_W-1:0]  shadow_words [WORD_COUNT];
   logic               overlap_seen;
   logic [COUNT_W-1:0] bit_count;
   answer_type         answer_queue [$];
   int                 results_seen;

   function automatic int lowest_one(input logic [WORD_W-1:0] w);
      int idx;
      idx = 0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) begin
            idx = i;
         end
      end
      return idx;
   endfunction

   // Apply one transfer to the shadow bitmap and return the answer it should produce.
   task automatic apply_request(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                                input logic [WORD_IDX_W-1:0] word_num,
                                input logic [WORD_W-1:0] operand, input logic last,
                                output answer_type answer);
      int                  wsel;
      int                  bsel;
      logic [WORD_W-1:0]   onehot;
      logic [WORD_W-1:0]   window;
      logic [WORD_W-1:0]   hits;
      bit                  done;
      wsel   = int'(pos[POS_W-1:BIT_IDX_W]);
      bsel   = int'(pos[BIT_IDX_W-1:0]);
      onehot = {{(WORD_W-1){1'b0}}, 1'b1} << bsel;
      answer = '0;
      case (func)
         FUNC_SET: begin
            if (wsel < WORD_COUNT) shadow_words[wsel] = shadow_words[wsel] | onehot;
         end
         FUNC_CLEAR: begin
            if (wsel < WORD_COUNT) shadow_words[wsel] = shadow_words[wsel] & ~onehot;
         end
         FUNC_MASK: begin
            if (wsel < WORD_COUNT) shadow_words[wsel] = shadow_words[wsel] & onehot;
         end
         FUNC_INTERSECT: begin
            if (int'(word_num) < WORD_COUNT) begin
               shadow_words[word_num] = shadow_words[word_num] & operand;
            end
         end
         FUNC_OVERLAP: begin
            if (int'(word_num) < WORD_COUNT && (shadow_words[word_num] & operand) != '0) begin
               overlap_seen = 1'b1;
            end
            answer.flag = overlap_seen;
            if (last) overlap_seen = 1'b0;
         end
         FUNC_ZERO: begin
            answer.flag = 1'b1;
            for (int i = 0; i < WORD_COUNT; i++) begin
               if (shadow_words[i] != '0) answer.flag = 1'b0;
            end
         end
         FUNC_FIND: begin
            if ({1'b0, pos} < bit_count && wsel < WORD_COUNT) begin
               // nothing of the start word lies above bit 63
               window = (bsel == WORD_W - 1) ? '0 : ({WORD_W{1'b1}} << (bsel + 1));
               done   = 1'b0;
               for (int w = wsel; w < WORD_COUNT && !done; w++) begin
                  hits = shadow_words[w] & window;
                  if (hits != '0) begin
                     answer.flag     = 1'b1;
                     answer.position = POS_W'(w * WORD_W + lowest_one(hits));
                     done            = 1'b1;
                  end
                  window = '1;
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("%0t ns: result %0d %s: got %0d, expected %0d",
                  $time, results_seen, what, got_v, want_v);
      end
   endtask

   always @(posedge clock) begin : watch
      answer_type got;
      answer_type want;
      answer_type predicted;
      if (reset) begin
         for (int i = 0; i < WORD_COUNT; i++) shadow_words[i] = '0;
         overlap_seen = 1'b0;
         bit_count    = BIT_COUNT_RESET;
         answer_queue.delete();
         results_seen = 0;
      end else begin
         if (csr_wr_en) bit_count = csr_wr_data;
         // retire before taking the new transfer, so a spurious result is caught
         if (rsp_tvalid && rsp_tready) begin
            got.flag     = rsp_tdata[0];
            got.position = rsp_tdata[8:1];
            if (answer_queue.size() == 0) begin
               report_mismatch("arrived with nothing outstanding", int'(got), 0);
            end else begin
               want = answer_queue.pop_front();
               if (got.flag !== want.flag)
                  report_mismatch("answer_flag", int'(got.flag), int'(want.flag));
               if (got.position !== want.position)
                  report_mismatch("found_position", int'(got.position), int'(want.position));
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) begin
            apply_request(req_tuser, req_tdata[7:0], req_tdata[9:8], req_tdata[73:10],
                          req_tlast, predicted);
            answer_queue.push_back(predicted);
         end
      end
      pending_count <= answer_queue.size();
   end

endmodule

>>> verif/tb_bitmap_set_find_next.sv
// Testbench top for bitmap_set_find_next: stimulus, idling, register phases and verdict.
`timescale 1ns / 1ps

module tb_bitmap_set_find_next;
   import bsfn_pkg::*;

   // code with no operation behind it
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // [7:0] bit_position, [9:8] word_number, [73:10] operand_word, [79:74] zero
   logic [79:0]  req_tdata;
   // [2:0] func
   logic [2:0]   req_tuser;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // [0] answer_flag, [8:1] found_position, [15:9] zero
   logic [15:0]  rsp_tdata;
   logic         csr_wr_en;
   logic [8:0]   csr_wr_data;

   int mismatch_count;
   int pending_count;

   // idling controls for the sender (gaps_on) and the receiver (stalls_on, hold_request, stall_left)
   bit gaps_on;
   bit stalls_on;
   bit hold_request;
   int stall_left;

   bitmap_set_find_next dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   bitmap_result_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case a transfer never completes.
   initial begin
      #5_000_000;
      $display("bitmap_set_find_next regression: fail");
      $finish;
   end

   // Mostly no pause, often a short one, now and then a long stretch.
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // Receiver: decide tready once per cycle; a pending hold request stalls it for long.
   initial begin
      rsp_tready <= 1'b0;
      stall_left = 0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = 150;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (stalls_on) stall_left = pick_pause();
         end
         @(posedge clock);
      end
   end

   // Drop valid for a random gap after a transfer, when gaps are enabled.
   task automatic sender_pause();
      int n;
      n = gaps_on ? pick_pause() : 0;
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Offer one item and hold it until the transfer completes.
   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                            input logic [WORD_IDX_W-1:0] word_num,
                            input logic [WORD_W-1:0] operand, input logic last);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tlast  <= last;
      req_tdata  <= {6'b0, operand, word_num, pos};
      do @(posedge clock); while (!req_tready);
      sender_pause();
   endtask

   // Stop offering and wait until every outstanding result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_bit_count(input logic [COUNT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Favor word boundaries and the ends of the bitmap.
   function automatic logic [POS_W-1:0] pick_position();
      logic [POS_W-1:0] edges [8];
      edges = '{8'd0, 8'd63, 8'd64, 8'd127, 8'd128, 8'd191, 8'd192, 8'd255};
      if ($urandom_range(0, 99) < 30) return edges[$urandom_range(0, 7)];
      return POS_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return {$urandom, $urandom};
      if (r < 65) return {{(WORD_W-1){1'b0}}, 1'b1} << $urandom_range(0, 63);
      if (r < 75) return '1;
      if (r < 85) return '0;
      return ~({{(WORD_W-1){1'b0}}, 1'b1} << $urandom_range(0, 63));
   endfunction

   // Intersect operands that keep most of the bitmap alive.
   function automatic logic [WORD_W-1:0] dense_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return ~({{(WORD_W-1){1'b0}}, 1'b1} << $urandom_range(0, 63));
      if (r < 80) return '1;
      return {$urandom, $urandom};
   endfunction

   task automatic random_item();
      int                r;
      logic [FUNC_W-1:0] func;
      logic [WORD_W-1:0] operand;
      r = $urandom_range(0, 99);
      if (r < 24)      func = FUNC_SET;
      else if (r < 34) func = FUNC_CLEAR;
      else if (r < 38) func = FUNC_MASK;
      else if (r < 45) func = FUNC_INTERSECT;
      else if (r < 57) func = FUNC_OVERLAP;
      else if (r < 67) func = FUNC_ZERO;
      else if (r < 94) func = FUNC_FIND;
      else             func = FUNC_UNUSED;
      operand = (func == FUNC_INTERSECT) ? dense_word() : pick_word();
      send_item(func, pick_position(), WORD_IDX_W'($urandom_range(0, 3)), operand,
                1'($urandom_range(0, 1)));
   endtask

   // A complete overlap test: every word in order, last marked on the final one.
   task automatic overlap_run();
      for (int w = 0; w < WORD_COUNT; w++) begin
         send_item(FUNC_OVERLAP, pick_position(), WORD_IDX_W'(w), pick_word(),
                   w == WORD_COUNT - 1);
      end
   endtask

   task automatic random_phase(input int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 12) begin
            overlap_run();
            sent += WORD_COUNT;
         end else begin
            random_item();
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      logic [COUNT_W-1:0] bit_count_plan [6];
      bit_count_plan = '{9'd256, 9'd1, 9'd511, 9'd0, 9'd130, 9'd64};
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= FUNC_SET;
      req_tlast    <= 1'b0;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      gaps_on      = 1'b1;
      stalls_on    = 1'b1;
      hold_request = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty map, boundary bits, search across words, overlap, wipes
      send_item(FUNC_ZERO,      8'd0,   2'd0, '0, 1'b0);
      send_item(FUNC_FIND,      8'd0,   2'd0, '0, 1'b0);
      send_item(FUNC_SET,       8'd0,   2'd0, '0, 1'b0);
      send_item(FUNC_SET,       8'd63,  2'd0, '0, 1'b0);
      send_item(FUNC_SET,       8'd64,  2'd0, '0, 1'b0);
      send_item(FUNC_SET,       8'd255, 2'd0, '0, 1'b0);
      send_item(FUNC_ZERO,      8'd0,   2'd0, '0, 1'b0);
      send_item(FUNC_FIND,      8'd0,   2'd0, '0, 1'b0);
      // start on bit 63: the search resumes at bit 0 of the next word
      send_item(FUNC_FIND,      8'd63,  2'd0, '0, 1'b0);
      send_item(FUNC_FIND,      8'd64,  2'd0, '0, 1'b0);
      send_item(FUNC_FIND,      8'd255, 2'd0, '0, 1'b0);
      send_item(FUNC_CLEAR,     8'd63,  2'd0, '0, 1'b0);
      send_item(FUNC_FIND,      8'd0,   2'd0, '0, 1'b0);
      send_item(FUNC_OVERLAP,   8'd0,   2'd1, 64'd1, 1'b0);
      send_item(FUNC_OVERLAP,   8'd0,   2'd0, '0, 1'b1);
      send_item(FUNC_OVERLAP,   8'd0,   2'd2, '1, 1'b1);
      send_item(FUNC_INTERSECT, 8'd0,   2'd3, 64'h8000_0000_0000_0000, 1'b0);
      send_item(FUNC_MASK,      8'd200, 2'd0, '0, 1'b0);
      send_item(FUNC_FIND,      8'd128, 2'd0, '0, 1'b0);
      send_item(FUNC_INTERSECT, 8'd0,   2'd1, '0, 1'b0);
      send_item(FUNC_UNUSED,    8'd255, 2'd3, '1, 1'b1);
      send_item(FUNC_ZERO,      8'd0,   2'd0, '0, 1'b0);
      send_item(FUNC_CLEAR,     8'd0,   2'd0, '0, 1'b0);
      send_item(FUNC_ZERO,      8'd0,   2'd0, '0, 1'b0);
      drain();

      for (int p = 0; p < 6; p++) begin
         write_bit_count(bit_count_plan[p]);
         if (p == 1) begin
            // back-pressure: hold the result side while items keep coming
            gaps_on      = 1'b0;
            hold_request = 1'b1;
            random_phase(20);
            gaps_on      = 1'b1;
            random_phase(43);
         end else if (p == 3) begin
            // a stretch with no idling on either side
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
            random_phase(63);
            gaps_on   = 1'b1;
            stalls_on = 1'b1;
         end else begin
            random_phase(63);
         end
         drain();
      end

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("bitmap_set_find_next regression: pass");
      end else begin
         $display("bitmap_set_find_next regression: fail");
      end
      $finish;
   end

endmodule

>>> bitmap_set_find_next.f
src/bsfn_pkg.sv
src/bsfn_datapath.sv
src/bsfn_ctrl.sv
src/bitmap_set_find_next.sv
verif/bitmap_result_checker.sv
verif/tb_bitmap_set_find_next.sv
